/* hw/rtl/lpcss_pkg.sv */
// ----------------------------------------------------------------------------
// LPC speech synthesiser package
// Shared constants, command codes, channel payload types and helper functions.
// ----------------------------------------------------------------------------
package lpcss_pkg;

	// Fixed synthesis constants
	localparam int FILTER_ORDER   = 10;
	localparam int SUBFRAME_COUNT = 8;
	localparam int CHIRP_LEN      = 15;
	localparam int OUTPUT_SHIFT   = 7;
	localparam int COEF_LIM       = 32760;
	localparam int PERIOD_MIN     = 2 * 256;

	// Command index wide enough for the largest frame layout (order 16)
	localparam int IDX_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 15;

	localparam logic [14:0] HIGHPASS_RESET  = 15'd32700;
	localparam logic [31:0] NOISE_SEED_INIT = 32'h51F15E3D;

	// Input operations
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_COMMIT = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEEMPH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS = 2'd2;

	// Excitation modes
	localparam logic [1:0] MODE_NOISE = 2'd0;
	localparam logic [1:0] MODE_MIXED = 2'd1;
	localparam logic [1:0] MODE_PULSE = 2'd2;
	localparam logic [1:0] MODE_BOOST = 2'd3;

	// Datapath command codes
	localparam logic [4:0] DP_NOP     = 5'd0;
	localparam logic [4:0] DP_QUEUE   = 5'd1;
	localparam logic [4:0] DP_CLEAR   = 5'd2;
	localparam logic [4:0] DP_LOAD    = 5'd3;
	localparam logic [4:0] DP_START   = 5'd4;
	localparam logic [4:0] DP_ADVANCE = 5'd5;
	localparam logic [4:0] DP_NOISE   = 5'd6;
	localparam logic [4:0] DP_HNOISE  = 5'd7;
	localparam logic [4:0] DP_PULSE   = 5'd8;
	localparam logic [4:0] DP_SRC     = 5'd9;
	localparam logic [4:0] DP_GAIN    = 5'd10;
	localparam logic [4:0] DP_TAP     = 5'd11;
	localparam logic [4:0] DP_SYNTH   = 5'd12;
	localparam logic [4:0] DP_DEEMPH  = 5'd13;
	localparam logic [4:0] DP_TILT    = 5'd14;
	localparam logic [4:0] DP_HP      = 5'd15;
	localparam logic [4:0] DP_EMIT    = 5'd16;

	typedef struct packed {
		logic [1:0]         op;
		logic [4:0]         param_index;
		logic signed [15:0] param_value;
	} lpcss_req_t;

	typedef struct packed {
		logic [7:0] pwm_level;
		logic       underrun;
		logic       finished;
		logic       fill_request;
	} lpcss_rsp_t;

	typedef struct packed {
		logic [4:0]       code;
		logic [IDX_W-1:0] idx;
	} lpcss_cmd_t;

	typedef struct packed {
		logic playing;
		logic frame_end;
		logic last_frame;
		logic queued_ready;
		logic sub_adv;
	} lpcss_stat_t;

	// Chirp pulse shape
	function automatic logic signed [15:0] chirp_val(input logic [3:0] pos);
		logic signed [15:0] r;
		unique case (pos)
			4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd12, 4'd14: r = -16'sd9044;
			default:                                    r = 16'sd7913;
		endcase
		return r;
	endfunction

	// Boost gain per subframe: 256 + ((7 - s) * 205) / 7
	function automatic logic [8:0] boost_gain(input logic [2:0] sub);
		logic [8:0] r;
		unique case (sub)
			3'd0:    r = 9'd461;
			3'd1:    r = 9'd431;
			3'd2:    r = 9'd402;
			3'd3:    r = 9'd373;
			3'd4:    r = 9'd343;
			3'd5:    r = 9'd314;
			3'd6:    r = 9'd285;
			default: r = 9'd256;
		endcase
		return r;
	endfunction

	// Clamp a wide signed value into a 16-bit range
	function automatic logic signed [15:0] sat16(input logic signed [35:0] v,
			input logic signed [35:0] lo, input logic signed [35:0] hi);
		logic signed [35:0] r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r[15:0];
	endfunction

endpackage

/* hw/rtl/lpcss_stream_if.sv */
// ----------------------------------------------------------------------------
// LPC speech synthesiser stream channel
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lpcss_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/lpcss_ram.sv */
// ----------------------------------------------------------------------------
// LPC speech synthesiser generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpcss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 28,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/lpcss_datapath.sv */
// ----------------------------------------------------------------------------
// LPC speech synthesiser datapath
// Frame state, excitation, lattice-free all-pole filter and post-filters, driven one
// command per cycle; noise-shaping, pulse, gain, tap and post-filter products share one 17x17 multiplier.
// ----------------------------------------------------------------------------
module lpcss_datapath #(
	parameter int FILTER_ORDER = lpcss_pkg::FILTER_ORDER
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lpcss_pkg::lpcss_cmd_t   cmd,
	output lpcss_pkg::lpcss_stat_t  stat,
	input  logic [15:0]             qword,
	input  logic [14:0]             deemph_coef,
	input  logic [14:0]             tilt_beta,
	input  logic [14:0]             hp_pole,
	output lpcss_pkg::lpcss_rsp_t   result
);

	localparam int KW    = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
	localparam int IW    = lpcss_pkg::IDX_W;
	localparam logic [IW-1:0] QI_GAIN    = IW'(2 * FILTER_ORDER);
	localparam logic [IW-1:0] QI_GSTEP   = IW'(2 * FILTER_ORDER + 1);
	localparam logic [IW-1:0] QI_PERIOD  = IW'(2 * FILTER_ORDER + 2);
	localparam logic [IW-1:0] QI_PSTEP   = IW'(2 * FILTER_ORDER + 3);
	localparam logic [IW-1:0] QI_PULSE   = IW'(2 * FILTER_ORDER + 4);
	localparam logic [IW-1:0] QI_USTEP   = IW'(2 * FILTER_ORDER + 5);
	localparam logic [IW-1:0] QI_SAMPLES = IW'(2 * FILTER_ORDER + 6);
	localparam logic [IW-1:0] QI_FLAGS   = IW'(2 * FILTER_ORDER + 7);

	// Frame state
	logic signed [15:0] coef_q [FILTER_ORDER];
	logic signed [15:0] step_q [FILTER_ORDER];
	logic signed [15:0] hist_q [FILTER_ORDER];
	logic [14:0]        gain_q, period_q, pulse_scale_q;
	logic signed [15:0] gstep_q, pstep_q, ustep_q;
	logic [15:0]        count_q;
	logic [4:0]         flags_q;
	logic               queued_ready_q, playing_q;
	logic [16:0]        sample_idx_q;
	logic [2:0]         sub_q;

	// Synthesis state
	logic signed [15:0] deemph_mem_q, tilt_mem_q, hp_in_q, hp_out_q, noise_mem_q;
	logic signed [16:0] pitch_q;
	logic [3:0]         chirp_pos_q;
	logic [31:0]        seed_q;
	logic [1:0]         last_mode_q, mode_q;

	// Per-sample working registers
	logic signed [12:0] noise_q;
	logic signed [13:0] hnoise_q, pulse_q;
	logic signed [15:0] src_q, y_q;
	logic signed [31:0] acc_q;
	lpcss_pkg::lpcss_rsp_t res_q, out_q;

	logic [KW-1:0]      tap_k;
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod, prod_q15, prod_q11;
	logic [18:0]        bnd;
	logic               fill_now, finish_now, under_now;

	// Noise and pitch step
	logic [1:0]         mode_now;
	logic               mode_rst;
	logic signed [17:0] pc0;
	logic [3:0]         cp0;
	logic [31:0]        s1, s2, s3;
	logic signed [12:0] noise_now;
	logic signed [23:0] src_w;
	logic signed [15:0] h_now, hs_sat;
	logic signed [15:0] hs;

	assign tap_k = cmd.idx[KW-1:0];

	// Status towards the controller
	assign bnd = 19'(4'({1'b0, sub_q} + 4'd1)) * 19'(count_q);
	assign stat.playing      = playing_q;
	assign stat.frame_end    = sample_idx_q >= {1'b0, count_q};
	assign stat.last_frame   = flags_q[0];
	assign stat.queued_ready = queued_ready_q;
	assign stat.sub_adv      = (sub_q != 3'd7) && (sample_idx_q >= {1'b0, bnd[18:3]});

	assign finish_now = playing_q && stat.frame_end && flags_q[0];
	assign under_now  = playing_q && stat.frame_end && !flags_q[0] && !queued_ready_q;
	assign fill_now   = playing_q && stat.frame_end && !flags_q[0] && queued_ready_q;

	// Shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.code)
			lpcss_pkg::DP_HNOISE: begin
				mul_a = 17'sd26870;
				mul_b = 17'(noise_mem_q);
			end
			lpcss_pkg::DP_PULSE: begin
				mul_a = 17'(lpcss_pkg::chirp_val(chirp_pos_q));
				mul_b = $signed({2'b00, pulse_scale_q});
			end
			lpcss_pkg::DP_GAIN: begin
				mul_a = 17'(src_q);
				mul_b = $signed({2'b00, gain_q});
			end
			lpcss_pkg::DP_TAP: begin
				mul_a = 17'(coef_q[tap_k]);
				mul_b = 17'(hist_q[tap_k]);
			end
			lpcss_pkg::DP_DEEMPH: begin
				mul_a = $signed({2'b00, deemph_coef});
				mul_b = 17'(deemph_mem_q);
			end
			lpcss_pkg::DP_TILT: begin
				mul_a = $signed({2'b00, tilt_beta});
				mul_b = 17'(tilt_mem_q);
			end
			lpcss_pkg::DP_HP: begin
				mul_a = $signed({2'b00, hp_pole});
				mul_b = 17'(hp_out_q);
			end
			default: ;
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_q15 = prod >>> 15;
	assign prod_q11 = prod >>> 11;

	// Excitation mode, pitch and noise for this sample
	always_comb begin
		mode_now = (sub_q < 3'd4) ? flags_q[2:1] : flags_q[4:3];
		mode_rst = ((last_mode_q == lpcss_pkg::MODE_NOISE) ||
			(last_mode_q == lpcss_pkg::MODE_BOOST)) &&
			((mode_now == lpcss_pkg::MODE_MIXED) || (mode_now == lpcss_pkg::MODE_PULSE));
		pc0 = mode_rst ? 18'sd0 : 18'(pitch_q);
		cp0 = mode_rst ? 4'(lpcss_pkg::CHIRP_LEN) : chirp_pos_q;
		if (pc0 <= 18'sd0) begin
			pc0 = pc0 + $signed({3'b000, period_q});
			cp0 = 4'd0;
		end
		s1 = seed_q ^ (seed_q << 13);
		s2 = s1 ^ (s1 >> 17);
		s3 = s2 ^ (s2 << 5);
		noise_now = 13'($signed(s3[31:24])) * 13'sd28;
	end

	// Source mix by mode
	always_comb begin
		case (mode_q)
			lpcss_pkg::MODE_PULSE:
				src_w = (24'sd241 * 24'(pulse_q) + 24'sd31 * 24'(noise_q)) >>> 8;
			lpcss_pkg::MODE_MIXED:
				src_w = (24'sd148 * 24'(pulse_q) + 24'sd159 * 24'(hnoise_q)) >>> 8;
			lpcss_pkg::MODE_BOOST:
				src_w = (24'(hnoise_q) * $signed({15'd0, lpcss_pkg::boost_gain(sub_q)})) >>> 8;
			default:
				src_w = 24'(noise_q);
		endcase
	end

	// Highpass output and PWM level
	always_comb begin
		h_now = lpcss_pkg::sat16(36'(y_q) - 36'(hp_in_q) + 36'(prod_q15), -36'sd16384,
			36'sd16384);
		hs = h_now >>> lpcss_pkg::OUTPUT_SHIFT;
		if (hs > 16'sd127) hs_sat = 16'sd127;
		else if (hs < -16'sd127) hs_sat = -16'sd127;
		else hs_sat = hs;
	end

	// Execute one command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILTER_ORDER; i++) begin
				coef_q[i] <= '0;
				step_q[i] <= '0;
				hist_q[i] <= '0;
			end
			gain_q         <= '0;
			period_q       <= '0;
			pulse_scale_q  <= '0;
			gstep_q        <= '0;
			pstep_q        <= '0;
			ustep_q        <= '0;
			count_q        <= '0;
			flags_q        <= '0;
			queued_ready_q <= 1'b0;
			playing_q      <= 1'b0;
			sample_idx_q   <= '0;
			sub_q          <= '0;
			deemph_mem_q   <= '0;
			tilt_mem_q     <= '0;
			hp_in_q        <= '0;
			hp_out_q       <= '0;
			noise_mem_q    <= '0;
			pitch_q        <= '0;
			chirp_pos_q    <= 4'(lpcss_pkg::CHIRP_LEN);
			seed_q         <= lpcss_pkg::NOISE_SEED_INIT;
			last_mode_q    <= lpcss_pkg::MODE_NOISE;
			mode_q         <= lpcss_pkg::MODE_NOISE;
			noise_q        <= '0;
			hnoise_q       <= '0;
			pulse_q        <= '0;
			src_q          <= '0;
			y_q            <= '0;
			acc_q          <= '0;
			res_q          <= '0;
			out_q          <= '0;
		end else begin
			case (cmd.code)
				lpcss_pkg::DP_QUEUE: queued_ready_q <= 1'b1;
				lpcss_pkg::DP_CLEAR: begin
					for (int i = 0; i < FILTER_ORDER; i++) hist_q[i] <= '0;
					deemph_mem_q <= '0;
					tilt_mem_q   <= '0;
					hp_in_q      <= '0;
					hp_out_q     <= '0;
					noise_mem_q  <= '0;
					pitch_q      <= '0;
					chirp_pos_q  <= 4'(lpcss_pkg::CHIRP_LEN);
					seed_q       <= lpcss_pkg::NOISE_SEED_INIT;
					last_mode_q  <= lpcss_pkg::MODE_NOISE;
					playing_q    <= 1'b1;
				end
				lpcss_pkg::DP_LOAD: begin
					sample_idx_q   <= '0;
					sub_q          <= '0;
					queued_ready_q <= 1'b0;
					for (int i = 0; i < FILTER_ORDER; i++) begin
						if (cmd.idx == IW'(i))
							coef_q[i] <= lpcss_pkg::sat16(36'($signed(qword)),
								-36'(lpcss_pkg::COEF_LIM), 36'(lpcss_pkg::COEF_LIM));
						if (cmd.idx == IW'(FILTER_ORDER + i))
							step_q[i] <= $signed(qword);
					end
					case (cmd.idx)
						QI_GAIN:    gain_q <= qword[15] ? 15'h7FFF : qword[14:0];
						QI_GSTEP:   gstep_q <= $signed(qword);
						QI_PERIOD:  period_q <= qword[15] ? 15'h7FFF :
							((qword < 16'(lpcss_pkg::PERIOD_MIN)) ?
							15'(lpcss_pkg::PERIOD_MIN) : qword[14:0]);
						QI_PSTEP:   pstep_q <= $signed(qword);
						QI_PULSE:   pulse_scale_q <= qword[15] ? 15'h7FFF : qword[14:0];
						QI_USTEP:   ustep_q <= $signed(qword);
						QI_SAMPLES: count_q <= qword;
						QI_FLAGS:   flags_q <= qword[4:0];
						default: ;
					endcase
				end
				lpcss_pkg::DP_START: begin
					res_q.pwm_level    <= 8'd128;
					res_q.underrun     <= under_now;
					res_q.finished     <= finish_now;
					res_q.fill_request <= fill_now;
					if (finish_now) playing_q <= 1'b0;
				end
				lpcss_pkg::DP_ADVANCE: begin
					sub_q <= sub_q + 3'd1;
					for (int i = 0; i < FILTER_ORDER; i++)
						coef_q[i] <= lpcss_pkg::sat16(36'(coef_q[i]) + 36'(step_q[i]),
							-36'(lpcss_pkg::COEF_LIM), 36'(lpcss_pkg::COEF_LIM));
					gain_q <= 15'(lpcss_pkg::sat16($signed({21'd0, gain_q}) + 36'(gstep_q),
						36'sd0, 36'sd32767));
					period_q <= 15'(lpcss_pkg::sat16($signed({21'd0, period_q}) + 36'(pstep_q),
						36'(lpcss_pkg::PERIOD_MIN), 36'sd32767));
					pulse_scale_q <= 15'(lpcss_pkg::sat16($signed({21'd0, pulse_scale_q}) +
						36'(ustep_q), 36'sd0, 36'sd32767));
				end
				lpcss_pkg::DP_NOISE: begin
					mode_q      <= mode_now;
					last_mode_q <= mode_now;
					pitch_q     <= 17'(pc0 - 18'sd256);
					chirp_pos_q <= cp0;
					seed_q      <= s3;
					noise_q     <= noise_now;
				end
				lpcss_pkg::DP_HNOISE: begin
					hnoise_q <= 14'(lpcss_pkg::sat16(36'(noise_q) - 36'(prod_q15),
						-36'sd8192, 36'sd8191));
					noise_mem_q <= 16'(noise_q);
				end
				lpcss_pkg::DP_PULSE: begin
					if (chirp_pos_q < 4'(lpcss_pkg::CHIRP_LEN)) begin
						pulse_q <= 14'(lpcss_pkg::sat16(36'(prod_q15), -36'sd8192, 36'sd8191));
						chirp_pos_q <= chirp_pos_q + 4'd1;
					end else begin
						pulse_q <= '0;
					end
				end
				lpcss_pkg::DP_SRC:  src_q <= src_w[15:0];
				lpcss_pkg::DP_GAIN: acc_q <= 32'(prod_q15);
				lpcss_pkg::DP_TAP:  acc_q <= acc_q - 32'(prod_q11);
				lpcss_pkg::DP_SYNTH: begin
					for (int i = 1; i < FILTER_ORDER; i++) hist_q[i] <= hist_q[i-1];
					hist_q[0] <= lpcss_pkg::sat16(36'(acc_q), -36'sd16384, 36'sd16384);
					y_q       <= lpcss_pkg::sat16(36'(acc_q), -36'sd16384, 36'sd16384);
				end
				lpcss_pkg::DP_DEEMPH: begin
					deemph_mem_q <= lpcss_pkg::sat16(36'(y_q) + 36'(prod_q15),
						-36'sd16384, 36'sd16384);
					y_q <= lpcss_pkg::sat16(36'(y_q) + 36'(prod_q15), -36'sd16384, 36'sd16384);
				end
				lpcss_pkg::DP_TILT: begin
					tilt_mem_q <= y_q;
					y_q <= lpcss_pkg::sat16(36'(y_q) - 36'(prod_q15), -36'sd16384, 36'sd16384);
				end
				lpcss_pkg::DP_HP: begin
					hp_in_q         <= y_q;
					hp_out_q        <= h_now;
					sample_idx_q    <= sample_idx_q + 17'd1;
					res_q.pwm_level <= 8'd128 + 8'(hs_sat);
				end
				lpcss_pkg::DP_EMIT: out_q <= res_q;
				default: ;
			endcase
		end
	end

	assign result = out_q;

endmodule

/* hw/rtl/lpcss_ctrl.sv */
// ----------------------------------------------------------------------------
// LPC speech synthesiser controller
// Sequences frame activation, subframe advance and the per-sample filter
// steps, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module lpcss_ctrl #(
	parameter int FILTER_ORDER = lpcss_pkg::FILTER_ORDER,
	localparam int QWORDS = 2 * FILTER_ORDER + 8,
	localparam int AW = $clog2(QWORDS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             in_op,
	output logic                   out_valid,
	input  logic                   out_ready,
	output lpcss_pkg::lpcss_cmd_t  cmd,
	input  lpcss_pkg::lpcss_stat_t stat,
	output logic                   ram_re,
	output logic [AW-1:0]          ram_raddr
);

	localparam int CW = $clog2(QWORDS + 1);
	localparam int KW = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
	localparam int IW = lpcss_pkg::IDX_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_COMMIT = 4'd1;
	localparam logic [3:0] S_TICK   = 4'd2;
	localparam logic [3:0] S_ACT    = 4'd3;
	localparam logic [3:0] S_ADV    = 4'd4;
	localparam logic [3:0] S_NOISE  = 4'd5;
	localparam logic [3:0] S_HNOISE = 4'd6;
	localparam logic [3:0] S_PULSE  = 4'd7;
	localparam logic [3:0] S_SRC    = 4'd8;
	localparam logic [3:0] S_GAIN   = 4'd9;
	localparam logic [3:0] S_TAP    = 4'd10;
	localparam logic [3:0] S_SYNTH  = 4'd11;
	localparam logic [3:0] S_DEEMPH = 4'd12;
	localparam logic [3:0] S_TILT   = 4'd13;
	localparam logic [3:0] S_HP     = 4'd14;
	localparam logic [3:0] S_OUT    = 4'd15;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] act_cnt_q;
	logic [KW-1:0] tap_q;
	logic          from_tick_q;
	logic          out_valid_q;
	logic          accept, emit;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign emit      = (cmd.code == lpcss_pkg::DP_EMIT);
	assign ram_raddr = act_cnt_q[AW-1:0];

	// Next state and command
	always_comb begin
		state_d  = state_q;
		cmd.code = lpcss_pkg::DP_NOP;
		cmd.idx  = '0;
		ram_re   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_op)
						lpcss_pkg::OP_TICK:   state_d = S_TICK;
						lpcss_pkg::OP_COMMIT: state_d = S_COMMIT;
						default: ;
					endcase
				end
			end
			S_COMMIT: begin
				if (stat.playing) begin
					cmd.code = lpcss_pkg::DP_QUEUE;
					state_d  = S_IDLE;
				end else begin
					cmd.code = lpcss_pkg::DP_CLEAR;
					state_d  = S_ACT;
				end
			end
			S_TICK: begin
				cmd.code = lpcss_pkg::DP_START;
				if (!stat.playing ||
						(stat.frame_end && (stat.last_frame || !stat.queued_ready)))
					state_d = S_OUT;
				else if (stat.frame_end)
					state_d = S_ACT;
				else
					state_d = S_ADV;
			end
			S_ACT: begin
				ram_re = (act_cnt_q < CW'(QWORDS));
				if (act_cnt_q != '0) begin
					cmd.code = lpcss_pkg::DP_LOAD;
					cmd.idx  = IW'(act_cnt_q - CW'(1));
				end
				if (act_cnt_q == CW'(QWORDS)) state_d = from_tick_q ? S_ADV : S_IDLE;
			end
			S_ADV: begin
				if (stat.sub_adv) cmd.code = lpcss_pkg::DP_ADVANCE;
				else state_d = S_NOISE;
			end
			S_NOISE: begin
				cmd.code = lpcss_pkg::DP_NOISE;
				state_d  = S_HNOISE;
			end
			S_HNOISE: begin
				cmd.code = lpcss_pkg::DP_HNOISE;
				state_d  = S_PULSE;
			end
			S_PULSE: begin
				cmd.code = lpcss_pkg::DP_PULSE;
				state_d  = S_SRC;
			end
			S_SRC: begin
				cmd.code = lpcss_pkg::DP_SRC;
				state_d  = S_GAIN;
			end
			S_GAIN: begin
				cmd.code = lpcss_pkg::DP_GAIN;
				state_d  = S_TAP;
			end
			S_TAP: begin
				cmd.code = lpcss_pkg::DP_TAP;
				cmd.idx  = IW'(tap_q);
				if (tap_q == KW'(FILTER_ORDER - 1)) state_d = S_SYNTH;
			end
			S_SYNTH: begin
				cmd.code = lpcss_pkg::DP_SYNTH;
				state_d  = S_DEEMPH;
			end
			S_DEEMPH: begin
				cmd.code = lpcss_pkg::DP_DEEMPH;
				state_d  = S_TILT;
			end
			S_TILT: begin
				cmd.code = lpcss_pkg::DP_TILT;
				state_d  = S_HP;
			end
			S_HP: begin
				cmd.code = lpcss_pkg::DP_HP;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.code = lpcss_pkg::DP_EMIT;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Advance state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_cnt_q   <= '0;
			tap_q       <= '0;
			from_tick_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != S_ACT) begin
				act_cnt_q   <= '0;
				from_tick_q <= (state_q == S_TICK);
			end else begin
				act_cnt_q <= act_cnt_q + CW'(1);
			end
			if (state_q == S_TAP) tap_q <= tap_q + KW'(1);
			else tap_q <= '0;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/lpc_speech_sample_synthesizer.sv */
// ----------------------------------------------------------------------------
// LPC speech sample synthesiser, top level
// Queued frame buffer, configuration registers, controller and datapath.
//
//   Channel  Dir  Handshake     Payload
//   req      in   valid/ready   op, param_index, param_value
//   rsp      out  valid/ready   pwm_level, underrun, finished, fill_request
//   cfg      in   cfg_we        cfg_index, cfg_data (no read-back)
//
// A tick runs the per-sample filter steps, with one subframe advance per subframe
// boundary crossed, and when a queued frame is swapped in it first loads each
// queued word through the buffer read port. A starting commit clears the filter
// state and loads the queued frame the same way. Reset clears all control and
// filter state at once. A result waiting on rsp holds the next tick only at
// its final step.
// ----------------------------------------------------------------------------
module lpc_speech_sample_synthesizer #(
	parameter int FILTER_ORDER = lpcss_pkg::FILTER_ORDER
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	lpcss_stream_if.sink                         req,
	lpcss_stream_if.source                       rsp,
	input  logic                                 cfg_we,
	input  logic [lpcss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lpcss_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int QWORDS = 2 * FILTER_ORDER + 8;
	localparam int AW     = $clog2(QWORDS);

	logic [14:0] deemph_coef_q, tilt_beta_q, hp_pole_q;
	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [15:0]            ram_rdata;
	lpcss_pkg::lpcss_cmd_t  cmd;
	lpcss_pkg::lpcss_stat_t stat;
	lpcss_pkg::lpcss_rsp_t  result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deemph_coef_q <= '0;
			tilt_beta_q   <= '0;
			hp_pole_q     <= lpcss_pkg::HIGHPASS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpcss_pkg::REG_DEEMPH:   deemph_coef_q <= cfg_data;
				lpcss_pkg::REG_TILT:     tilt_beta_q   <= cfg_data;
				lpcss_pkg::REG_HIGHPASS: hp_pole_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Store a frame word on a write item inside the layout
	assign ram_we = req.valid && req.ready && (req.data.op == lpcss_pkg::OP_WRITE) &&
		(6'(req.data.param_index) < 6'(QWORDS));

	lpcss_ram #(
		.WIDTH(16),
		.DEPTH(QWORDS)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(req.data.param_index)),
		.wdata (req.data.param_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lpcss_ctrl #(
		.FILTER_ORDER(FILTER_ORDER)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.data.op),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	lpcss_datapath #(
		.FILTER_ORDER(FILTER_ORDER)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.qword       (ram_rdata),
		.deemph_coef (deemph_coef_q),
		.tilt_beta   (tilt_beta_q),
		.hp_pole     (hp_pole_q),
		.result      (result)
	);

	assign rsp.data = result;

endmodule

/* hw/rtl/lpcss_checker.sv */
// ----------------------------------------------------------------------------
// LPC speech synthesiser port checker
// Checks result stability, result origin and flag consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
module lpcss_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [1:0]            in_op,
	input logic                  out_valid,
	input logic                  out_ready,
	input lpcss_pkg::lpcss_rsp_t out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Only a tick may produce a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_op != lpcss_pkg::OP_TICK) |=> !$rose(out_valid))
		else $error("result appeared after a non-tick item");

	// Frame-end events give a silent level
	a_silent_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.underrun || out_data.finished) |-> out_data.pwm_level == 8'd128)
		else $error("underrun or finish with non-silent level");

	// Flags exclude one another
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({out_data.underrun, out_data.finished, out_data.fill_request}))
		else $error("more than one status flag set");

endmodule

bind lpc_speech_sample_synthesizer lpcss_checker u_lpcss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.in_op     (req.data.op),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.data)
);

/* verif/tb_lpc_speech_sample_synthesizer.sv */
// ----------------------------------------------------------------------------
// LPC speech sample synthesiser testbench
// Loads frames word by word, commits them and ticks out samples. Both channels
// idle at random, and the output is held off once for a long stretch so that
// the block backs up. A scoreboard predicts each sample, with its underrun,
// finished and fill flags, and checks every result in order. The
// configuration registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_lpc_speech_sample_synthesizer;

	localparam int QWORDS      = 2 * lpcss_pkg::FILTER_ORDER + 8;
	localparam int QI_SCALAR   = 2 * lpcss_pkg::FILTER_ORDER;
	localparam int QI_SAMPLES  = 2 * lpcss_pkg::FILTER_ORDER + 6;
	localparam int QI_FLAGS    = 2 * lpcss_pkg::FILTER_ORDER + 7;
	localparam int TARGET      = 1200;
	localparam int SETTLE      = 120;
	localparam int HOLD_CYCLES = 3000;
	localparam int LIMIT       = 1500000;
	localparam logic [1:0] OP_IGNORED = 2'd3;

	// Predicts samples from the accepted requests and checks the results
	class lpc_sample_scoreboard;
		longint deemph_coef, tilt_beta, hp_pole;
		longint coef[lpcss_pkg::FILTER_ORDER], coef_inc[lpcss_pkg::FILTER_ORDER];
		longint gain, period, pulse_scale, scalar_inc[3];
		longint frame_len;
		logic [4:0]  flags;
		logic [15:0] queued[QWORDS];
		bit          queued_ready, playing;
		longint      sample_idx, sub_idx;
		longint      history[lpcss_pkg::FILTER_ORDER], mem[5];
		longint      pitch_cnt;
		int          chirp_pos;
		logic [31:0] seed;
		logic [1:0]  prev_mode;
		longint      chirp_shape[lpcss_pkg::CHIRP_LEN];
		lpcss_pkg::lpcss_rsp_t pending_samples[$];
		int          errors;

		function new();
			chirp_shape = '{7913, 7913, 7913, 7913, -9044, -9044, -9044, 7913,
				-9044, -9044, 7913, 7913, -9044, 7913, -9044};
			deemph_coef = 0;
			tilt_beta = 0;
			hp_pole = 32700;
			foreach (coef[i]) begin
				coef[i] = 0;
				coef_inc[i] = 0;
			end
			gain = 0;
			period = 0;
			pulse_scale = 0;
			scalar_inc = '{0, 0, 0};
			frame_len = 0;
			flags = '0;
			foreach (queued[i]) queued[i] = '0;
			queued_ready = 0;
			playing = 0;
			sample_idx = 0;
			sub_idx = 0;
			errors = 0;
			clear_filters();
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function longint word_signed(logic [15:0] v);
			return longint'($signed(v));
		endfunction

		function void clear_filters();
			foreach (history[i]) history[i] = 0;
			foreach (mem[i]) mem[i] = 0;
			pitch_cnt = 0;
			chirp_pos = lpcss_pkg::CHIRP_LEN;
			seed = lpcss_pkg::NOISE_SEED_INIT;
			prev_mode = lpcss_pkg::MODE_NOISE;
		endfunction

		function void load_queued();
			for (int i = 0; i < lpcss_pkg::FILTER_ORDER; i++) begin
				coef[i] = clamp(word_signed(queued[i]), -lpcss_pkg::COEF_LIM,
					lpcss_pkg::COEF_LIM);
				coef_inc[i] = word_signed(queued[lpcss_pkg::FILTER_ORDER + i]);
			end
			gain = clamp(longint'(queued[QI_SCALAR]), 0, 32767);
			scalar_inc[0] = word_signed(queued[QI_SCALAR + 1]);
			period = clamp(longint'(queued[QI_SCALAR + 2]), lpcss_pkg::PERIOD_MIN, 32767);
			scalar_inc[1] = word_signed(queued[QI_SCALAR + 3]);
			pulse_scale = clamp(longint'(queued[QI_SCALAR + 4]), 0, 32767);
			scalar_inc[2] = word_signed(queued[QI_SCALAR + 5]);
			frame_len = longint'(queued[QI_SAMPLES]);
			flags = queued[QI_FLAGS][4:0];
			sample_idx = 0;
			sub_idx = 0;
			queued_ready = 0;
		endfunction

		function void next_subframe();
			sub_idx++;
			foreach (coef[i]) coef[i] = clamp(coef[i] + coef_inc[i], -lpcss_pkg::COEF_LIM,
				lpcss_pkg::COEF_LIM);
			gain = clamp(gain + scalar_inc[0], 0, 32767);
			period = clamp(period + scalar_inc[1], lpcss_pkg::PERIOD_MIN, 32767);
			pulse_scale = clamp(pulse_scale + scalar_inc[2], 0, 32767);
		endfunction

		function void set_reg(logic [lpcss_pkg::CFG_IDX_W-1:0] idx,
				logic [lpcss_pkg::CFG_DATA_W-1:0] v);
			case (idx)
				lpcss_pkg::REG_DEEMPH:   deemph_coef = longint'(v);
				lpcss_pkg::REG_TILT:     tilt_beta = longint'(v);
				lpcss_pkg::REG_HIGHPASS: hp_pole = longint'(v);
				default: ;
			endcase
		endfunction

		// Work out one tick's sample and flags
		function lpcss_pkg::lpcss_rsp_t render_tick();
			lpcss_pkg::lpcss_rsp_t r;
			logic [1:0] mode;
			longint noise, hnoise, pulse, src, acc, y, d, bright, high, boost;
			r = '{pwm_level: 8'd128, underrun: 1'b0, finished: 1'b0, fill_request: 1'b0};
			pulse = 0;
			if (!playing) return r;
			if (sample_idx >= frame_len) begin
				if (flags[0]) begin
					playing = 0;
					r.finished = 1'b1;
					return r;
				end
				if (!queued_ready) begin
					r.underrun = 1'b1;
					return r;
				end
				load_queued();
				r.fill_request = 1'b1;
			end
			while (sub_idx < lpcss_pkg::SUBFRAME_COUNT - 1 &&
					sample_idx >= ((sub_idx + 1) * frame_len) / lpcss_pkg::SUBFRAME_COUNT)
				next_subframe();
			mode = (sub_idx < lpcss_pkg::SUBFRAME_COUNT / 2) ? flags[2:1] : flags[4:3];
			if ((prev_mode == lpcss_pkg::MODE_NOISE || prev_mode == lpcss_pkg::MODE_BOOST) &&
					(mode == lpcss_pkg::MODE_MIXED || mode == lpcss_pkg::MODE_PULSE)) begin
				pitch_cnt = 0;
				chirp_pos = lpcss_pkg::CHIRP_LEN;
			end
			prev_mode = mode;
			seed = seed ^ (seed << 13);
			seed = seed ^ (seed >> 17);
			seed = seed ^ (seed << 5);
			noise = longint'($signed(seed[31:24])) * 28;
			hnoise = clamp(noise - ((26870 * mem[4]) >>> 15), -8192, 8191);
			mem[4] = noise;
			if (pitch_cnt <= 0) begin
				pitch_cnt += period;
				chirp_pos = 0;
			end
			pitch_cnt -= 256;
			if (chirp_pos < lpcss_pkg::CHIRP_LEN) begin
				pulse = clamp((chirp_shape[chirp_pos] * pulse_scale) >>> 15, -8192, 8191);
				chirp_pos++;
			end
			case (mode)
				lpcss_pkg::MODE_PULSE: src = (241 * pulse + 31 * noise) >>> 8;
				lpcss_pkg::MODE_MIXED: src = (148 * pulse + 159 * hnoise) >>> 8;
				lpcss_pkg::MODE_BOOST: begin
					boost = 256 + ((7 - sub_idx) * 205) / 7;
					src = (hnoise * boost) >>> 8;
				end
				default: src = noise;
			endcase
			acc = (src * gain) >>> 15;
			foreach (coef[i]) acc -= (coef[i] * history[i]) >>> 11;
			y = clamp(acc, -16384, 16384);
			for (int i = lpcss_pkg::FILTER_ORDER - 1; i > 0; i--) history[i] = history[i - 1];
			history[0] = y;
			d = clamp(y + ((deemph_coef * mem[0]) >>> 15), -16384, 16384);
			mem[0] = d;
			bright = clamp(d - ((tilt_beta * mem[1]) >>> 15), -16384, 16384);
			mem[1] = d;
			high = clamp(bright - mem[2] + ((hp_pole * mem[3]) >>> 15), -16384, 16384);
			mem[2] = bright;
			mem[3] = high;
			sample_idx = (sample_idx + 1) & 'h1FFFF;
			r.pwm_level = 8'(128 + clamp(high >>> lpcss_pkg::OUTPUT_SHIFT, -127, 127));
			return r;
		endfunction

		function void note_request(lpcss_pkg::lpcss_req_t q);
			case (q.op)
				lpcss_pkg::OP_WRITE:
					if (q.param_index < QWORDS) queued[q.param_index] = q.param_value;
				lpcss_pkg::OP_COMMIT: begin
					if (playing) queued_ready = 1;
					else begin
						clear_filters();
						load_queued();
						playing = 1;
					end
				end
				lpcss_pkg::OP_TICK: pending_samples.push_back(render_tick());
				default: ;
			endcase
		endfunction

		task report(string what);
			errors++;
			$display("mismatch: %s", what);
		endtask

		task check_sample(lpcss_pkg::lpcss_rsp_t got);
			lpcss_pkg::lpcss_rsp_t want;
			if (pending_samples.size() == 0) begin
				report($sformatf("unexpected sample %p", got));
				return;
			end
			want = pending_samples.pop_front();
			if (got.pwm_level !== want.pwm_level)
				report($sformatf("pwm_level %0d, want %0d", got.pwm_level, want.pwm_level));
			if (got.underrun !== want.underrun)
				report($sformatf("underrun %b, want %b", got.underrun, want.underrun));
			if (got.finished !== want.finished)
				report($sformatf("finished %b, want %b", got.finished, want.finished));
			if (got.fill_request !== want.fill_request)
				report($sformatf("fill_request %b, want %b", got.fill_request,
					want.fill_request));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lpcss_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lpcss_pkg::CFG_DATA_W-1:0] cfg_data;

	lpcss_stream_if #(.T(lpcss_pkg::lpcss_req_t)) req_ch ();
	lpcss_stream_if #(.T(lpcss_pkg::lpcss_rsp_t)) rsp_ch ();

	lpc_speech_sample_synthesizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lpc_sample_scoreboard sb = new();
	int  item_count;
	bit  steady;
	bit  hold_req;
	int  hold_left;
	logic [15:0] frame_words[QWORDS];

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// Output side: random stalls, one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= arst_n && (steady || $urandom_range(0, 99) >= 36);
			end
		end
	end

	// Check each accepted sample
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) sb.check_sample(rsp_ch.data);
	end

	// Offer one item, idling at random first, and note it once accepted
	task automatic send(logic [1:0] op, logic [4:0] idx, logic [15:0] val);
		lpcss_pkg::lpcss_req_t q;
		q = '{op: op, param_index: idx, param_value: val};
		while (!steady && $urandom_range(0, 99) < 36) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= q;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(q);
		if (op != OP_IGNORED && !(op == lpcss_pkg::OP_WRITE && idx >= QWORDS)) item_count++;
	endtask

	task automatic tick(int n);
		repeat (n) send(lpcss_pkg::OP_TICK, 5'($urandom), 16'($urandom));
	endtask

	task automatic write_frame();
		for (int i = 0; i < QWORDS; i++) send(lpcss_pkg::OP_WRITE, 5'(i), frame_words[i]);
	endtask

	// Random frame content; wild frames use the full word range
	task automatic make_frame(int max_len);
		bit wild;
		wild = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < lpcss_pkg::FILTER_ORDER; i++) begin
			frame_words[i] = wild ? 16'($urandom) : 16'($signed($urandom_range(0, 3000)) - 1500);
			frame_words[lpcss_pkg::FILTER_ORDER + i] = wild ? 16'($urandom)
				: 16'($signed($urandom_range(0, 400)) - 200);
		end
		for (int i = 0; i < 6; i += 2) begin
			frame_words[QI_SCALAR + i] = wild ? 16'($urandom) : 16'($urandom_range(0, 24000));
			frame_words[QI_SCALAR + i + 1] = wild ? 16'($urandom)
				: 16'($signed($urandom_range(0, 1000)) - 500);
		end
		frame_words[QI_SAMPLES] = 16'($urandom_range(0, max_len));
		frame_words[QI_FLAGS] = {11'($urandom), 4'($urandom), $urandom_range(0, 3) == 0};
	endtask

	// Drop the request valid, then wait out all results and the block's own work
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Present one register write for a single edge; the caller drops the enable
	task automatic write_reg(logic [lpcss_pkg::CFG_IDX_W-1:0] idx,
			logic [lpcss_pkg::CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic set_regs(logic [14:0] de, logic [14:0] ti, logic [14:0] hp);
		write_reg(lpcss_pkg::REG_DEEMPH, de);
		write_reg(lpcss_pkg::REG_TILT, ti);
		write_reg(lpcss_pkg::REG_HIGHPASS, hp);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int phase;
		int pick;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_count = 0;
		steady = 0;
		hold_req = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: top extremes of the registers
		set_regs(15'd32440, 15'd32700, 15'd32767);
		// Tick while stopped, unknown op, writes beyond the frame layout
		tick(1);
		send(OP_IGNORED, 5'd31, 16'hFFFF);
		send(lpcss_pkg::OP_WRITE, 5'd28, 16'h1234);
		send(lpcss_pkg::OP_WRITE, 5'd31, 16'hFFFF);
		// Frame at the field extremes: saturated coefficients, gain, period
		foreach (frame_words[i])
			frame_words[i] = i[0] ? 16'h8000 : 16'h7FFF;
		frame_words[QI_SCALAR]     = 16'hFFFF;
		frame_words[QI_SCALAR + 2] = 16'h0000;
		frame_words[QI_SCALAR + 4] = 16'hFFFF;
		frame_words[QI_SAMPLES]    = 16'd3;
		frame_words[QI_FLAGS]      = {11'd0, lpcss_pkg::MODE_BOOST, lpcss_pkg::MODE_PULSE,
			1'b0};
		write_frame();
		send(lpcss_pkg::OP_COMMIT, 5'd0, 16'd0);
		// Arm a swap twice, then rewrite words while ready: zero-sample, last
		send(lpcss_pkg::OP_COMMIT, 5'd0, 16'd0);
		send(lpcss_pkg::OP_COMMIT, 5'd0, 16'd0);
		send(lpcss_pkg::OP_WRITE, 5'(QI_SAMPLES), 16'd0);
		send(lpcss_pkg::OP_WRITE, 5'(QI_FLAGS),
			{11'd0, lpcss_pkg::MODE_MIXED, lpcss_pkg::MODE_MIXED, 1'b1});
		tick(8);
		drain();

		// Random phases, each with its own register setting
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_regs(15'd0, 15'd0, 15'd0);
				1: set_regs(15'($urandom_range(0, 32440)), 15'($urandom_range(0, 32700)),
					15'($urandom));
				2: set_regs(15'h7FFF, 15'h7FFF, 15'd32700);
				default: set_regs(15'd32440, 15'd0, 15'd32767);
			endcase
			while (item_count < (phase + 1) * TARGET / 4) begin
				steady = (phase == 1 && item_count < 360);
				if (phase == 2 && !hold_req && hold_left == 0 && item_count > 700 &&
						item_count < 720) begin
					hold_req = 1;
					tick(40);
				end
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					make_frame($urandom_range(0, 9) == 0 ? 120 : 30);
					write_frame();
					send(lpcss_pkg::OP_COMMIT, 5'($urandom), 16'($urandom));
					tick($urandom_range(0, 35));
				end else if (pick == 6) begin
					send(lpcss_pkg::OP_COMMIT, 5'($urandom), 16'($urandom));
					tick($urandom_range(1, 20));
				end else if (pick == 7) begin
					send(OP_IGNORED, 5'($urandom), 16'($urandom));
					send(lpcss_pkg::OP_WRITE, 5'($urandom_range(QWORDS, 31)), 16'($urandom));
					send(lpcss_pkg::OP_WRITE, 5'($urandom_range(0, QWORDS - 1)),
						16'($urandom));
					tick($urandom_range(1, 5));
				end else begin
					tick($urandom_range(1, 20));
				end
			end
			steady = 0;
			drain();
		end

		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/lpcss_pkg.sv
hw/rtl/lpcss_stream_if.sv
hw/rtl/lpcss_ram.sv
hw/rtl/lpcss_datapath.sv
hw/rtl/lpcss_ctrl.sv
hw/rtl/lpc_speech_sample_synthesizer.sv
hw/rtl/lpcss_checker.sv
verif/tb_lpc_speech_sample_synthesizer.sv
